// ----- hw/rtl/dual_wheel_incremental_pid_speed_defines.svh -----
// assertion macros shared by the speed loop rtl
`ifndef DUAL_WHEEL_INCREMENTAL_PID_SPEED_DEFINES_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_SPEED_DEFINES_SVH

// same-cycle implication
`define DWPID_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DWPID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dwpid_pkg.sv -----
// types and constants of the dual wheel speed loop
package dwpid_pkg;

   localparam int MAX_LANES   = 2;
   localparam int STAGES      = 5;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int MAG_W       = 28;
   localparam int PROD_W      = MAG_W + 32;
   localparam int RECIP_SHIFT = 35;

   localparam logic [31:0] RECIP_10       = 32'hCCCC_CCCD;
   localparam logic [15:0] TARGET_RESET   = 16'd150;
   localparam logic [15:0] MAX_DUTY_RESET = 16'd50000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_P_GAIN       = 3'd0,
      CSR_I_GAIN       = 3'd1,
      CSR_D_GAIN       = 3'd2,
      CSR_TARGET_SPEED = 3'd3,
      CSR_MAX_DUTY     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [14:0] count_left;
      logic        dir_left;
      logic [14:0] count_right;
      logic        dir_right;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_left;
      logic [15:0] duty_right;
   } rsp_type;

   typedef struct packed {
      logic [9:0]         p_gain;
      logic [9:0]         i_gain;
      logic [9:0]         d_gain;
      logic signed [15:0] target_speed;
      logic [15:0]        max_duty;
   } cfg_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } lane_ctrl_type;

endpackage

// ----- hw/rtl/dwpid_csr.sv -----
// configuration registers of the speed loop
module dwpid_csr
   import dwpid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_P_GAIN:       cfg_in.p_gain       = csr_wdata[9:0];
            CSR_I_GAIN:       cfg_in.i_gain       = csr_wdata[9:0];
            CSR_D_GAIN:       cfg_in.d_gain       = csr_wdata[9:0];
            CSR_TARGET_SPEED: cfg_in.target_speed = $signed(csr_wdata);
            CSR_MAX_DUTY:     cfg_in.max_duty     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain       <= '0;
         cfg_ff.i_gain       <= '0;
         cfg_ff.d_gain       <= '0;
         cfg_ff.target_speed <= $signed(TARGET_RESET);
         cfg_ff.max_duty     <= MAX_DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/dwpid_lane.sv -----
// one wheel of the incremental pid: error, products, divide by ten, duty update
module dwpid_lane
   import dwpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  cfg_type       cfg,
   input  logic [14:0]   count,
   input  logic          negate,
   output logic [15:0]   duty
);

   // error history and duty, reset to zero
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] older_ff, older_in;
   logic [15:0]        duty_ff, duty_in;

   // stage 0: error and its differences
   logic signed [15:0] speed;
   logic signed [15:0] err;
   logic signed [15:0] e_ff;
   logic signed [16:0] d1_ff, d1_in;
   logic signed [18:0] d2_ff, d2_in;

   assign speed = negate ? -$signed({1'b0, count}) : $signed({1'b0, count});
   assign err   = cfg.target_speed - speed;
   assign d1_in = $signed({err[15], err}) - $signed({prev_ff[15], prev_ff});
   assign d2_in = $signed({{3{err[15]}}, err})
                - $signed({{2{prev_ff[15]}}, prev_ff, 1'b0})
                + $signed({{3{older_ff[15]}}, older_ff});
   assign prev_in  = ctrl.load[0] ? err : prev_ff;
   assign older_in = ctrl.load[0] ? prev_ff : older_ff;

   // stage 1: gain products
   logic signed [27:0] pp_ff, pp_in;
   logic signed [26:0] pi_ff, pi_in;
   logic signed [29:0] pd_ff, pd_in;

   assign pp_in = $signed({1'b0, cfg.p_gain}) * d1_ff;
   assign pi_in = $signed({1'b0, cfg.i_gain}) * e_ff;
   assign pd_in = $signed({1'b0, cfg.d_gain}) * d2_ff;

   // stage 2: sum, split into sign and magnitude
   logic signed [29:0] sum;
   logic [29:0]        abs_sum;
   logic               sneg_ff;
   logic [MAG_W-1:0]   mag_ff;

   assign sum = $signed({{2{pp_ff[27]}}, pp_ff})
              + $signed({{3{pi_ff[26]}}, pi_ff})
              + pd_ff;
   assign abs_sum = sum[29] ? 30'(-sum) : 30'(sum);

   // stage 3: divide by ten through the reciprocal, low 16 bits kept
   logic [PROD_W-1:0] prod;
   logic              qneg_ff;
   logic [15:0]       q_ff;

   assign prod = mag_ff * RECIP_10;

   // stage 4: signed increment, accumulate and clamp
   logic [15:0]        inc;
   logic signed [17:0] acc;

   assign inc = qneg_ff ? (~q_ff + 16'd1) : q_ff;
   assign acc = $signed({2'b00, duty_ff}) + $signed({{2{inc[15]}}, inc});

   always_comb begin
      duty_in = duty_ff;
      if (ctrl.load[4]) begin
         if (acc[17]) begin
            duty_in = '0;
         end else if (acc[16:0] > {1'b0, cfg.max_duty}) begin
            duty_in = cfg.max_duty;
         end else begin
            duty_in = acc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         older_ff <= '0;
         duty_ff  <= '0;
      end else begin
         prev_ff  <= prev_in;
         older_ff <= older_in;
         duty_ff  <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         e_ff  <= err;
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
      if (ctrl.load[1]) begin
         pp_ff <= pp_in;
         pi_ff <= pi_in;
         pd_ff <= pd_in;
      end
      if (ctrl.load[2]) begin
         sneg_ff <= sum[29];
         mag_ff  <= abs_sum[MAG_W-1:0];
      end
      if (ctrl.load[3]) begin
         qneg_ff <= sneg_ff;
         q_ff    <= prod[RECIP_SHIFT+15:RECIP_SHIFT];
      end
   end

   assign duty = duty_ff;

endmodule

// ----- hw/rtl/dual_wheel_incremental_pid_speed.sv -----
// top level of the dual wheel incremental pid speed loop
// One request beat is one control period: the encoder counts and direction pins of
// both wheels. Each wheel has its own lane running a velocity-form pid with the
// shared gains and target; the new duty, clamped to zero and max_duty, comes back
// as one response beat with both duties. Every lane is a five-stage pipeline
// (error, gain products, sum, divide by ten, accumulate), and a new beat can be taken
// every cycle while responses are taken; throughput is one beat per cycle, set by
// the stage valid chain, which collapses bubbles so requests keep flowing while a
// response waits. Error history updates when a beat is accepted and the duty in the
// output stage, so back-to-back beats see each other's state. With WHEELS at 1 only
// the left lane is built and duty_right reads zero; values above 2 build two lanes.
// Configuration must be written only while no beat is in flight; the block itself
// does not enforce this.
`include "dual_wheel_incremental_pid_speed_defines.svh"

module dual_wheel_incremental_pid_speed
   import dwpid_pkg::*;
#(
   parameter int WHEELS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   // configuration
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LANES = (WHEELS < MAX_LANES) ? WHEELS : MAX_LANES;

   cfg_type cfg;

   dwpid_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // stage valid chain, last stage is the response register
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] free;
   logic [STAGES-1:0] take;
   lane_ctrl_type     ctrl;

   always_comb begin
      take[STAGES-1] = valid_ff[STAGES-1] & rsp_ready;
      free[STAGES-1] = ~valid_ff[STAGES-1] | take[STAGES-1];
      for (int s = STAGES - 2; s >= 0; s--) begin
         take[s] = valid_ff[s] & free[s+1];
         free[s] = ~valid_ff[s] | take[s];
      end
      ctrl.load[0] = req_valid & free[0];
      for (int s = 1; s < STAGES; s++) begin
         ctrl.load[s] = take[s-1];
      end
      valid_in = ctrl.load | (valid_ff & ~take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = free[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // lane inputs: left speed positive on a high pin, right wheel mirrored
   logic [14:0] lane_count [MAX_LANES];
   logic        lane_neg   [MAX_LANES];
   logic [15:0] lane_duty  [MAX_LANES];

   assign lane_count[0] = req_data.count_left;
   assign lane_neg[0]   = ~req_data.dir_left;
   assign lane_count[1] = req_data.count_right;
   assign lane_neg[1]   = req_data.dir_right;

   for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
      if (l < LANES) begin : g_on
         dwpid_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .cfg    (cfg),
            .count  (lane_count[l]),
            .negate (lane_neg[l]),
            .duty   (lane_duty[l])
         );
      end else begin : g_off
         // wheel not built, duty reads zero
         assign lane_duty[l] = '0;
      end
   end

   // merge the lanes into the response beat
   assign rsp_data.duty_left  = lane_duty[0];
   assign rsp_data.duty_right = lane_duty[1];

   // a held stage is never overwritten
   `DWPID_ASSERT_NOW(a_no_overwrite, clock, reset, 1'b1,
      (ctrl.load & valid_ff & ~take) == '0, "pipeline stage overwritten")

   // duties respect the clamp while a response is shown
   `DWPID_ASSERT_NOW(a_duty_clamp, clock, reset, rsp_valid,
      rsp_data.duty_left <= cfg.max_duty && rsp_data.duty_right <= cfg.max_duty,
      "duty above max_duty")

   // an accepted request occupies the first stage
   `DWPID_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready,
      valid_ff[0], "accepted beat lost at first stage")

endmodule
